// File: design/bbl_pkg.sv
// ----------------------------------------------------------------------------
// bbl_pkg: shared types and constants of the bouncing beam LED block
// Field widths, configuration register codes and the payload structs that
// travel between the front end, the frame queue and the LED back end.
// ----------------------------------------------------------------------------
package bbl_pkg;

    // Strip size
    localparam int NUM_LEDS  = 32;
    localparam int IDX_W     = 6;
    localparam int LED_LOG   = $clog2(NUM_LEDS + 1) - 1;

    // Field widths
    localparam int TIME_W    = 48;
    localparam int CYC_W     = 24;
    localparam int FRAC_W    = 8;
    localparam int COLOR_W   = 8;
    localparam int BEAM_W    = CYC_W + FRAC_W;
    localparam int BEND_W    = BEAM_W + 1;
    localparam int LEND_W    = CYC_W + 1;
    localparam int SLOT_W    = CYC_W - LED_LOG;
    localparam int PROD_W    = CYC_W + IDX_W;
    localparam int NUM_W     = SLOT_W + COLOR_W;

    // Iterative divider
    localparam int DIV_W     = TIME_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Brightness divider stages, one quotient bit each
    localparam int BRT_STAGES = COLOR_W;

    // Configuration register codes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_NUM  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_DEN  = 2'd3;

    // Reset values
    localparam logic [CYC_W-1:0]  CYCLE_RESET = 24'd1000000;
    localparam logic [FRAC_W-1:0] NUM_RESET   = 8'd1;
    localparam logic [FRAC_W-1:0] DEN_RESET   = 8'd4;

    typedef struct packed {
        logic [TIME_W-1:0] start_time_us;
        logic [CYC_W-1:0]  cycle_time_us;
        logic [FRAC_W-1:0] beam_width_num;
        logic [FRAC_W-1:0] beam_width_den;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]  now_us;
        logic [COLOR_W-1:0] hue;
        logic [COLOR_W-1:0] saturation;
    } in_t;

    typedef struct packed {
        logic [IDX_W-1:0]   led_index;
        logic               lit;
        logic [COLOR_W-1:0] out_hue;
        logic [COLOR_W-1:0] out_saturation;
        logic [COLOR_W-1:0] brightness;
        logic               last;
    } out_t;

    // One frame as classified by the front end
    typedef struct packed {
        logic [CYC_W-1:0]   bstart;
        logic [BEAM_W-1:0]  beam;
        logic [COLOR_W-1:0] hue;
        logic [COLOR_W-1:0] sat;
    } frame_t;

    // Per-LED tag carried down the back-end pipeline
    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic               last;
        logic [COLOR_W-1:0] hue;
        logic [COLOR_W-1:0] sat;
    } tag_t;

    typedef struct packed {
        tag_t               tag;
        logic               lit;
        logic [NUM_W-1:0]   rem;
        logic [COLOR_W-1:0] quo;
    } brt_t;

endpackage

// File: design/bbl_div.sv
// ----------------------------------------------------------------------------
// bbl_div: iterative restoring divider
// One quotient bit per cycle over the full dividend width; done pulses for
// one cycle when quotient and remainder are valid.
// ----------------------------------------------------------------------------
module bbl_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [bbl_pkg::DIV_W-1:0]      dividend,
    input  logic [bbl_pkg::CYC_W-1:0]      divisor,
    output logic                           done,
    output logic [bbl_pkg::DIV_W-1:0]      quotient,
    output logic [bbl_pkg::CYC_W-1:0]      remainder
);

    logic                              run_reg;
    logic                              done_reg;
    logic [bbl_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [bbl_pkg::DIV_W-1:0]         dq_reg;
    logic [bbl_pkg::CYC_W-1:0]         rem_reg;
    logic [bbl_pkg::CYC_W-1:0]         dvs_reg;

    logic [bbl_pkg::CYC_W:0]           trial;
    logic                              ge;
    logic [bbl_pkg::CYC_W-1:0]         rem_next;
    logic [bbl_pkg::CYC_W:0]           diff;

    // One compare-subtract step
    always_comb begin
        trial    = {rem_reg, dq_reg[bbl_pkg::DIV_W-1]};
        ge       = trial >= {1'b0, dvs_reg};
        diff     = trial - {1'b0, dvs_reg};
        rem_next = ge ? diff[bbl_pkg::CYC_W-1:0] : trial[bbl_pkg::CYC_W-1:0];
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == bbl_pkg::DIV_CNT_W'(bbl_pkg::DIV_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out the top, quotient shifts in the bottom
    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (run_reg) begin
            dq_reg  <= {dq_reg[bbl_pkg::DIV_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

// File: design/bbl_front.sv
// ----------------------------------------------------------------------------
// bbl_front: frame intake and beam position
// Buffers one frame, derives the beam width (cached until the next
// configuration write) and the beam start from the elapsed time.
// ----------------------------------------------------------------------------
module bbl_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  bbl_pkg::cfg_t     cfg,
    input  logic              cfg_wr,
    input  logic              s_valid,
    output logic              s_ready,
    input  bbl_pkg::in_t      s_data,
    output logic              q_valid,
    input  logic              q_ready,
    output bbl_pkg::frame_t   q_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_BEAM = 3'd1;
    localparam logic [2:0] ST_SPAN = 3'd2;
    localparam logic [2:0] ST_ELAP = 3'd3;
    localparam logic [2:0] ST_PUSH = 3'd4;

    logic [2:0]                      state_reg, state_next;
    logic                            buf_vld_reg;
    bbl_pkg::in_t                    buf_reg;
    bbl_pkg::in_t                    work_reg;
    logic                            beam_ok_reg;
    logic [bbl_pkg::BEAM_W-1:0]      beam_reg;
    logic [bbl_pkg::CYC_W-1:0]       span_reg;
    logic [bbl_pkg::CYC_W-1:0]       bstart_reg;

    logic                            div_start;
    logic [bbl_pkg::DIV_W-1:0]       div_dividend;
    logic [bbl_pkg::CYC_W-1:0]       div_divisor;
    logic                            div_done;
    logic [bbl_pkg::DIV_W-1:0]       div_quo;
    logic [bbl_pkg::CYC_W-1:0]       div_rem;

    logic [bbl_pkg::BEAM_W-1:0]      beam_prod;
    logic [bbl_pkg::FRAC_W-1:0]      den;
    logic                            span_pos;
    logic [bbl_pkg::CYC_W-1:0]       span_val;
    logic [bbl_pkg::TIME_W-1:0]      elapsed;

    bbl_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign s_ready = !buf_vld_reg;

    // Beam and span arithmetic
    always_comb begin
        den       = (cfg.beam_width_den == '0) ? bbl_pkg::FRAC_W'(1) : cfg.beam_width_den;
        beam_prod = bbl_pkg::BEAM_W'(cfg.cycle_time_us) * bbl_pkg::BEAM_W'(cfg.beam_width_num);
        span_pos  = beam_reg < bbl_pkg::BEAM_W'(cfg.cycle_time_us);
        span_val  = cfg.cycle_time_us - beam_reg[bbl_pkg::CYC_W-1:0];
        elapsed   = (work_reg.now_us > cfg.start_time_us) ?
                    work_reg.now_us - cfg.start_time_us : '0;
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = bbl_pkg::DIV_W'(beam_prod);
        div_divisor  = bbl_pkg::CYC_W'(den);
        case (state_reg)
            ST_IDLE: begin
                if (buf_vld_reg) begin
                    if (beam_ok_reg) begin
                        state_next = ST_SPAN;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_BEAM;
                    end
                end
            end
            ST_BEAM: begin
                if (div_done) begin
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN: begin
                if (span_pos) begin
                    div_start    = 1'b1;
                    div_dividend = elapsed;
                    div_divisor  = span_val;
                    state_next   = ST_ELAP;
                end else begin
                    state_next = ST_PUSH;
                end
            end
            ST_ELAP: begin
                if (div_done) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (q_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            buf_vld_reg <= 1'b0;
            beam_ok_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_valid && s_ready) begin
                buf_vld_reg <= 1'b1;
            end else if (state_reg == ST_IDLE) begin
                buf_vld_reg <= 1'b0;
            end
            if (cfg_wr) begin
                beam_ok_reg <= 1'b0;
            end else if (state_reg == ST_BEAM && div_done) begin
                beam_ok_reg <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            buf_reg <= s_data;
        end
        if (state_reg == ST_IDLE && buf_vld_reg) begin
            work_reg <= buf_reg;
        end
        if (state_reg == ST_BEAM && div_done) begin
            beam_reg <= div_quo[bbl_pkg::BEAM_W-1:0];
        end
        if (state_reg == ST_SPAN) begin
            span_reg   <= span_val;
            bstart_reg <= '0;
        end
        // Odd pass runs forward, even pass backward
        if (state_reg == ST_ELAP && div_done) begin
            bstart_reg <= div_quo[0] ? div_rem : span_reg - div_rem;
        end
    end

    assign q_valid       = (state_reg == ST_PUSH);
    assign q_data.bstart = bstart_reg;
    assign q_data.beam   = beam_reg;
    assign q_data.hue    = work_reg.hue;
    assign q_data.sat    = work_reg.saturation;

endmodule

// File: design/bbl_fifo.sv
// ----------------------------------------------------------------------------
// bbl_fifo: two-entry frame queue
// Decouples the front end from the LED back end.
// ----------------------------------------------------------------------------
module bbl_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  bbl_pkg::frame_t   wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output bbl_pkg::frame_t   rd_data
);

    bbl_pkg::frame_t  mem_reg [0:1];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (do_rd && !do_wr) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: design/bbl_back.sv
// ----------------------------------------------------------------------------
// bbl_back: per-LED overlap and brightness pipeline
// Issues one LED per cycle from the head frame unless stalled, finds its
// beam overlap, divides 255*overlap by slot time, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bbl_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  bbl_pkg::cfg_t     cfg,
    input  logic              q_valid,
    output logic              q_ready,
    input  bbl_pkg::frame_t   q_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bbl_pkg::out_t     m_data
);

    localparam logic [bbl_pkg::IDX_W-1:0] LAST_IDX = bbl_pkg::IDX_W'(bbl_pkg::NUM_LEDS - 1);
    localparam int NS = bbl_pkg::BRT_STAGES;

    logic                            adv;
    logic [bbl_pkg::SLOT_W-1:0]      slot;
    logic [bbl_pkg::IDX_W-1:0]       idx_reg;

    // Stage 0: issue
    logic                            s0_vld_reg;
    bbl_pkg::tag_t                   s0_tag_reg;
    logic [bbl_pkg::PROD_W-1:0]      s0_prod_reg;
    logic [bbl_pkg::CYC_W-1:0]       s0_bst_reg;
    logic [bbl_pkg::BEAM_W-1:0]      s0_beam_reg;

    // Stage 1: slot bounds, beam end
    logic                            s1_vld_reg;
    bbl_pkg::tag_t                   s1_tag_reg;
    logic [bbl_pkg::CYC_W-1:0]       s1_lstart_reg;
    logic [bbl_pkg::LEND_W-1:0]      s1_lend_reg;
    logic [bbl_pkg::CYC_W-1:0]       s1_bst_reg;
    logic [bbl_pkg::BEND_W-1:0]      s1_bend_reg;

    // Stage 2: hit test and overlap bounds
    logic                            s2_vld_reg;
    bbl_pkg::tag_t                   s2_tag_reg;
    logic                            s2_lit_reg;
    logic [bbl_pkg::CYC_W-1:0]       s2_s_reg;
    logic [bbl_pkg::LEND_W-1:0]      s2_e_reg;

    // Divider stages
    logic                            dv_vld_reg [0:NS];
    bbl_pkg::brt_t                   dv_reg     [0:NS];
    bbl_pkg::brt_t                   dv_next    [1:NS];

    logic                            out_vld_reg;
    bbl_pkg::out_t                   out_reg;

    logic [bbl_pkg::CYC_W-1:0]       lstart;
    logic [bbl_pkg::LEND_W-1:0]      on_full;
    logic [bbl_pkg::SLOT_W-1:0]      on;
    logic [bbl_pkg::NUM_W-1:0]       trial [1:NS];

    assign slot    = bbl_pkg::SLOT_W'(cfg.cycle_time_us / bbl_pkg::NUM_LEDS);
    assign adv     = !out_vld_reg || m_ready;
    assign q_ready = adv && (idx_reg == LAST_IDX);

    assign lstart  = bbl_pkg::CYC_W'(s0_prod_reg / bbl_pkg::NUM_LEDS);
    assign on_full = s2_e_reg - {1'b0, s2_s_reg};
    assign on      = on_full[bbl_pkg::SLOT_W-1:0];

    // Restoring division steps, one quotient bit per stage
    always_comb begin
        for (int k = 1; k <= NS; k++) begin
            trial[k]   = bbl_pkg::NUM_W'(slot) << (NS - k);
            dv_next[k] = dv_reg[k-1];
            if (dv_reg[k-1].rem >= trial[k]) begin
                dv_next[k].rem        = dv_reg[k-1].rem - trial[k];
                dv_next[k].quo[NS-k]  = 1'b1;
            end
        end
    end

    // LED counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (adv && q_valid) begin
            idx_reg <= (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
        end
    end

    // Valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k <= NS; k++) begin
                dv_vld_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            s0_vld_reg    <= q_valid;
            s1_vld_reg    <= s0_vld_reg;
            s2_vld_reg    <= s1_vld_reg;
            dv_vld_reg[0] <= s2_vld_reg;
            for (int k = 1; k <= NS; k++) begin
                dv_vld_reg[k] <= dv_vld_reg[k-1];
            end
            out_vld_reg   <= dv_vld_reg[NS];
        end
    end

    // Datapath stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            // issue
            s0_tag_reg.idx  <= idx_reg;
            s0_tag_reg.last <= (idx_reg == LAST_IDX);
            s0_tag_reg.hue  <= q_data.hue;
            s0_tag_reg.sat  <= q_data.sat;
            s0_prod_reg     <= bbl_pkg::PROD_W'(cfg.cycle_time_us) *
                               bbl_pkg::PROD_W'(idx_reg);
            s0_bst_reg      <= q_data.bstart;
            s0_beam_reg     <= q_data.beam;

            // slot bounds
            s1_tag_reg    <= s0_tag_reg;
            s1_lstart_reg <= lstart;
            s1_lend_reg   <= bbl_pkg::LEND_W'(lstart) + bbl_pkg::LEND_W'(slot);
            s1_bst_reg    <= s0_bst_reg;
            s1_bend_reg   <= bbl_pkg::BEND_W'(s0_bst_reg) + bbl_pkg::BEND_W'(s0_beam_reg);

            // hit test, overlap = [max(starts), min(ends))
            s2_tag_reg <= s1_tag_reg;
            s2_lit_reg <= ({1'b0, s1_bst_reg} < s1_lend_reg) &&
                          (s1_bend_reg > bbl_pkg::BEND_W'(s1_lstart_reg));
            s2_s_reg   <= (s1_bst_reg > s1_lstart_reg) ? s1_bst_reg : s1_lstart_reg;
            s2_e_reg   <= (s1_bend_reg < bbl_pkg::BEND_W'(s1_lend_reg)) ?
                          s1_bend_reg[bbl_pkg::LEND_W-1:0] : s1_lend_reg;

            // dividend 255*overlap
            dv_reg[0].tag <= s2_tag_reg;
            dv_reg[0].lit <= s2_lit_reg;
            dv_reg[0].rem <= (bbl_pkg::NUM_W'(on) << bbl_pkg::COLOR_W) - bbl_pkg::NUM_W'(on);
            dv_reg[0].quo <= '0;
            for (int k = 1; k <= NS; k++) begin
                dv_reg[k] <= dv_next[k];
            end

            // result; unlit LEDs are black, a zero slot gives zero brightness
            out_reg.led_index <= dv_reg[NS].tag.idx;
            out_reg.last      <= dv_reg[NS].tag.last;
            out_reg.lit       <= dv_reg[NS].lit;
            if (dv_reg[NS].lit) begin
                out_reg.out_hue        <= dv_reg[NS].tag.hue;
                out_reg.out_saturation <= dv_reg[NS].tag.sat;
                out_reg.brightness     <= (slot == '0) ? '0 : dv_reg[NS].quo;
            end else begin
                out_reg.out_hue        <= '0;
                out_reg.out_saturation <= '0;
                out_reg.brightness     <= '0;
            end
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

endmodule

// File: design/bouncing_beam_led_brightness.sv
// ----------------------------------------------------------------------------
// bouncing_beam_led_brightness: anti-aliased bouncing beam LED scanner
// Turns one frame update (time, hue, saturation) into one result per LED.
// ----------------------------------------------------------------------------
// Usage:
//   s_*   frame input: now_us, hue, saturation. One transaction per frame.
//   m_*   LED results: NUM_LEDS transactions per frame, in LED order, last
//         set on the final LED.
//   cfg_* register writes: start time, cycle time, beam width num/den.
//         Always ready; write only while no frame is in flight.
// From frame accept to the first result a frame passes the front end, where
//   the 48-step elapsed-time divider runs, the frame queue and then the LED
//   pipeline. The first frame after a register write also waits for the
//   beam width divide.
// The divider in the front end limits the frame rate; the back end emits
//   one LED per cycle while the receiver is ready.
// A two-frame queue separates front and back, and one input frame buffers
//   while another divides. A stalled receiver freezes the LED pipeline; the
//   front end keeps working until the queue fills.
// Reset (aresetn low, synchronous) empties all stages and restores the
//   register defaults: start 0, cycle 1000000 us, width 1/4.
// ----------------------------------------------------------------------------
module bouncing_beam_led_brightness (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  bbl_pkg::in_t                      s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output bbl_pkg::out_t                     m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bbl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bbl_pkg::TIME_W-1:0]        cfg_data
);

    bbl_pkg::cfg_t    cfg_reg;
    logic             cfg_wr;
    logic             q_wr_valid;
    logic             q_wr_ready;
    bbl_pkg::frame_t  q_wr_data;
    logic             q_rd_valid;
    logic             q_rd_ready;
    bbl_pkg::frame_t  q_rd_data;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_time_us  <= '0;
            cfg_reg.cycle_time_us  <= bbl_pkg::CYCLE_RESET;
            cfg_reg.beam_width_num <= bbl_pkg::NUM_RESET;
            cfg_reg.beam_width_den <= bbl_pkg::DEN_RESET;
        end else if (cfg_wr) begin
            case (cfg_index)
                bbl_pkg::CFG_START_TIME: cfg_reg.start_time_us  <= cfg_data;
                bbl_pkg::CFG_CYCLE_TIME: cfg_reg.cycle_time_us  <=
                                             cfg_data[bbl_pkg::CYC_W-1:0];
                bbl_pkg::CFG_WIDTH_NUM:  cfg_reg.beam_width_num <=
                                             cfg_data[bbl_pkg::FRAC_W-1:0];
                bbl_pkg::CFG_WIDTH_DEN:  cfg_reg.beam_width_den <=
                                             cfg_data[bbl_pkg::FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    bbl_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .cfg_wr  (cfg_wr),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_wr_valid),
        .q_ready (q_wr_ready),
        .q_data  (q_wr_data)
    );

    bbl_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    bbl_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_rd_valid),
        .q_ready (q_rd_ready),
        .q_data  (q_rd_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
